[rtl/htsed_pkg.sv]
// Package: beat types, window type and tag/entity match functions.
`timescale 1ns / 1ps
package htsed_pkg;

    localparam int WinDepth = 6;
    localparam int PatLen   = 5;

    localparam logic [7:0] ChLt    = 8'h3C;
    localparam logic [7:0] ChGt    = 8'h3E;
    localparam logic [7:0] ChAmp   = 8'h26;
    localparam logic [7:0] ChQuot  = 8'h22;
    localparam logic [7:0] ChSpace = 8'h20;
    localparam logic [7:0] ChNl    = 8'h0A;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_char;
        logic       out_is_char;
        logic       out_last;
    } t_out_beat;

    typedef logic [WinDepth-1:0][7:0] t_win;
    typedef logic [0:PatLen-1][7:0]   t_pat;

    typedef struct packed {
        logic       emit;
        logic [7:0] ch;
        logic [2:0] used;
        logic       in_tag;
    } t_head;

    localparam t_pat PatBr    = {"<br", 16'h0};
    localparam t_pat PatP     = {"<p", 24'h0};
    localparam t_pat PatEndP  = {"</p", 16'h0};
    localparam t_pat PatDiv   = {"<div", 8'h0};
    localparam t_pat PatEndDv = "</div";
    localparam t_pat PatLi    = {"<li", 16'h0};
    localparam t_pat PatEndH  = {"</h", 16'h0};
    localparam t_pat PatAmp   = {"amp;", 8'h0};
    localparam t_pat PatLtE   = {"lt;", 16'h0};
    localparam t_pat PatGtE   = {"gt;", 16'h0};
    localparam t_pat PatQuot  = "quot;";
    localparam t_pat PatNbsp  = "nbsp;";

    function automatic logic [7:0] fold_case(logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= 8'h41 && b <= 8'h5A) begin
            r = b + 8'd32;
        end
        return r;
    endfunction

    function automatic logic win_has(t_win w, logic [2:0] f, int pos, t_pat pat, int len,
                                     logic nocase);
        logic       ok;
        logic [7:0] b;
        logic [2:0] idx;
        ok = (pos + len <= int'(f));
        for (int i = 0; i < PatLen; i++) begin
            if (i < len && pos + i < WinDepth) begin
                idx = 3'(pos + i);
                b = w[idx];
                if (nocase) begin
                    b = fold_case(b);
                end
                if (b != pat[i]) begin
                    ok = 1'b0;
                end
            end
        end
        return ok;
    endfunction

    function automatic t_win drop_front(t_win w, logic [2:0] n);
        t_win r;
        r = w;
        for (int i = 0; i < WinDepth; i++) begin
            if (i + int'(n) < WinDepth) begin
                r[i] = w[3'(i + int'(n))];
            end
        end
        return r;
    endfunction

    function automatic t_head handle_head(t_win w, logic [2:0] f, logic in_tag);
        t_head h;
        logic [7:0] b;
        b        = w[0];
        h.emit   = 1'b0;
        h.ch     = b;
        h.used   = 3'd1;
        h.in_tag = in_tag;
        if (b == ChLt) begin
            h.in_tag = 1'b1;
            if (win_has(w, f, 0, PatBr, 3, 1'b1) || win_has(w, f, 0, PatP, 2, 1'b1) ||
                win_has(w, f, 0, PatEndP, 3, 1'b1) || win_has(w, f, 0, PatDiv, 4, 1'b1) ||
                win_has(w, f, 0, PatEndDv, 5, 1'b1) || win_has(w, f, 0, PatLi, 3, 1'b1) ||
                win_has(w, f, 0, PatEndH, 3, 1'b1)) begin
                h.emit = 1'b1;
                h.ch   = ChNl;
            end
        end else if (in_tag) begin
            if (b == ChGt) begin
                h.in_tag = 1'b0;
            end
        end else if (b == ChAmp) begin
            h.emit = 1'b1;
            h.ch   = ChAmp;
            if (win_has(w, f, 1, PatAmp, 4, 1'b0)) begin
                h.used = 3'd5;
            end else if (win_has(w, f, 1, PatLtE, 3, 1'b0)) begin
                h.ch   = ChLt;
                h.used = 3'd4;
            end else if (win_has(w, f, 1, PatGtE, 3, 1'b0)) begin
                h.ch   = ChGt;
                h.used = 3'd4;
            end else if (win_has(w, f, 1, PatQuot, 5, 1'b0)) begin
                h.ch   = ChQuot;
                h.used = 3'd6;
            end else if (win_has(w, f, 1, PatNbsp, 5, 1'b0)) begin
                h.ch   = ChSpace;
                h.used = 3'd6;
            end
        end else begin
            h.emit = 1'b1;
        end
        return h;
    endfunction

endpackage

[rtl/html_tag_strip_entity_decode.sv]
// Top level: HTML tag stripper and entity decoder over a six-byte window.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+------------------------------------
//  in       | i_in_valid / o_in_ready     | i_in_data  (in_byte, in_last)
//  out      | o_out_valid / i_out_ready   | o_out_data (out_char, out_is_char, out_last)
//
// One byte per cycle unless held off; a beat that fills the window handles the head
// token, and its result beat is loaded into the output register at that same edge.
// A beat with in_last starts a drain: head tokens are handled in turn, then the end
// marker is sent, each step waiting for output room; input is held off meanwhile.
// Synchronous active-low reset empties the window and the output register.
// The output register stalls the input only while it is full and not taken.
`timescale 1ns / 1ps
module html_tag_strip_entity_decode
    import htsed_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_data
);

    t_win      r_win, n_win;
    logic [2:0] r_fill, n_fill;
    logic      r_in_tag, n_in_tag;
    logic      r_drain, n_drain;
    logic      r_ov, n_ov;
    t_out_beat r_out, n_out;

    logic      slot_free;
    logic      in_fire;
    t_win      w_app;
    logic [2:0] f_app;
    t_win      h_win;
    logic [2:0] h_fill;
    t_head     hd;

    assign slot_free   = !r_ov || i_out_ready;
    assign o_in_ready  = !r_drain && slot_free;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    always_comb begin
        w_app = r_win;
        w_app[r_fill] = i_in_data.in_byte;
        f_app = r_fill + 3'd1;
        h_win  = r_drain ? r_win : w_app;
        h_fill = r_drain ? r_fill : f_app;
        hd = handle_head(h_win, h_fill, r_in_tag);
    end

    always_comb begin
        n_win    = r_win;
        n_fill   = r_fill;
        n_in_tag = r_in_tag;
        n_drain  = r_drain;
        n_ov     = r_ov && !i_out_ready;
        n_out    = r_out;
        if (in_fire) begin
            if (i_in_data.in_last) begin
                n_win   = w_app;
                n_fill  = f_app;
                n_drain = 1'b1;
            end else if (f_app == 3'(WinDepth)) begin
                n_win    = drop_front(w_app, hd.used);
                n_fill   = f_app - hd.used;
                n_in_tag = hd.in_tag;
                if (hd.emit) begin
                    n_ov  = 1'b1;
                    n_out = '{out_char: hd.ch, out_is_char: 1'b1, out_last: 1'b0};
                end
            end else begin
                n_win  = w_app;
                n_fill = f_app;
            end
        end else if (r_drain && slot_free) begin
            if (r_fill == 3'd0) begin
                n_drain  = 1'b0;
                n_in_tag = 1'b0;
                n_ov     = 1'b1;
                n_out    = '{out_char: 8'd0, out_is_char: 1'b0, out_last: 1'b1};
            end else begin
                n_win    = drop_front(r_win, hd.used);
                n_fill   = r_fill - hd.used;
                n_in_tag = hd.in_tag;
                if (hd.emit) begin
                    n_ov  = 1'b1;
                    n_out = '{out_char: hd.ch, out_is_char: 1'b1, out_last: 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= 3'd0;
            r_in_tag <= 1'b0;
            r_drain  <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_fill   <= n_fill;
            r_in_tag <= n_in_tag;
            r_drain  <= n_drain;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
        r_out <= n_out;
    end

endmodule

[rtl/htsed_checker.sv]
// Checker: port-level assertions for the tag stripper, bound to the top level.
`timescale 1ns / 1ps
module htsed_checker
    import htsed_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_beat  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_beat o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output beat dropped or changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_end_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.out_last |->
            !o_out_data.out_is_char && o_out_data.out_char == 8'd0)
        else $error("end marker carries a character");

    a_char_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.out_is_char |-> !o_out_data.out_last)
        else $error("text beat flagged as last");

    a_drain_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.in_last |=> !o_in_ready)
        else $error("input taken right after the last byte");

endmodule

bind html_tag_strip_entity_decode htsed_checker u_htsed_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

[tb/html_tag_strip_entity_decode_tb.sv]
// Testbench: HTML tag stripper / entity decoder checked against typed expectations and its own predictor.
`timescale 1ns / 1ps
module html_tag_strip_entity_decode_tb;
    import htsed_pkg::*;

    localparam int DirRows    = 22;
    localparam int RandBytes  = 90;
    localparam int CycleLimit = 200000;
    localparam int HoldStart  = 150;
    localparam int HoldLen    = 120;
    localparam int MaxReports = 100;
    localparam int NumFrags   = 26;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_beat  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_beat o_out_data;

    html_tag_strip_entity_decode dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // "*" = no typed expectation, checked against the predictor only
    string dir_text [DirRows] = '{
        "\001", "\377", "a&amp;b", "&lt;&gt;", "&quot;x&nbsp;", "&AMP;", "&&amp",
        "<BR>x<Li>", "<p>a</P>", "<DIV>b</div>", "</H2>c<b>d", "<i>e</i>", "x>y",
        "<a href=q>&amp;", "<p", "a</di", "zz&lt", "<unclosed", "q",
        "Tom &amp; Jerry<br>\200\376", "&nbsp&quot;<LI>x</Div>", "<<p>>&gt&gt;"
    };
    string dir_want [DirRows] = '{
        "\001", "\377", "a&b", "<>", "\"x ", "&AMP;", "&&amp",
        "\nx\n", "\na\n", "\nb\n", "\ncd", "e", "x>y",
        "&", "\n", "a", "zz&lt", "", "q",
        "*", "*", "*"
    };
    string frags [NumFrags] = '{
        "<br>", "<BR/>", "<p>", "</P>", "<div class=a>", "</DiV>", "<li>", "</h3>",
        "<b>", "</i>", "<p", "&amp;", "&lt;", "&gt;", "&quot;", "&nbsp;", "&am",
        "&lt", "&QUOT;", "&", ">", "<", " ", "ab", "Hello", "x;"
    };

    t_in_beat   stim_q [$];
    int         stim_row [$];
    logic [7:0] text_buf [$];
    t_out_beat  want_beats [$];

    logic [7:0] win [WinDepth];
    int         fill;
    logic       in_tag;
    logic       at_start = 1'b1;

    int mismatches;
    int acc_cnt;
    int cyc_total;
    int rx_cyc;
    int run_left;
    int ready_pct;

    function automatic logic win_match(int pos, string pat, logic nocase);
        logic [7:0] w;
        if (pos + pat.len() > fill) return 1'b0;
        for (int i = 0; i < pat.len(); i++) begin
            w = win[pos + i];
            if (nocase && w >= "A" && w <= "Z") w = w + 8'd32;
            if (w != pat[i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic take_head(output logic emit, output logic [7:0] ch);
        logic [7:0] b;
        int used;
        b = win[0];
        used = 1;
        emit = 1'b0;
        ch = b;
        if (b == ChLt) begin
            in_tag = 1'b1;
            if (win_match(0, "<br", 1'b1) || win_match(0, "<p", 1'b1) ||
                win_match(0, "</p", 1'b1) || win_match(0, "<div", 1'b1) ||
                win_match(0, "</div", 1'b1) || win_match(0, "<li", 1'b1) ||
                win_match(0, "</h", 1'b1)) begin
                emit = 1'b1;
                ch = ChNl;
            end
        end else if (in_tag) begin
            if (b == ChGt) in_tag = 1'b0;
        end else if (b == ChAmp) begin
            emit = 1'b1;
            if (win_match(1, "amp;", 1'b0)) begin
                used = 5;
            end else if (win_match(1, "lt;", 1'b0)) begin
                ch = ChLt;
                used = 4;
            end else if (win_match(1, "gt;", 1'b0)) begin
                ch = ChGt;
                used = 4;
            end else if (win_match(1, "quot;", 1'b0)) begin
                ch = ChQuot;
                used = 6;
            end else if (win_match(1, "nbsp;", 1'b0)) begin
                ch = ChSpace;
                used = 6;
            end
        end else begin
            emit = 1'b1;
        end
        for (int i = 0; i < WinDepth; i++) begin
            win[i] = (i + used < WinDepth) ? win[i + used] : 8'h00;
        end
        fill = fill - used;
    endtask

    task automatic predict_byte(t_in_beat beat, logic keep);
        logic       emit;
        logic [7:0] ch;
        int         n;
        if (fill < WinDepth) begin
            win[fill] = beat.in_byte;
            fill++;
        end
        if (!beat.in_last) begin
            if (fill >= WinDepth) begin
                take_head(emit, ch);
                if (emit && keep)
                    want_beats.push_back('{out_char: ch, out_is_char: 1'b1, out_last: 1'b0});
            end
        end else begin
            n = 0;
            while (fill > 0 && n < WinDepth) begin
                take_head(emit, ch);
                if (emit) begin
                    n++;
                    if (keep)
                        want_beats.push_back('{out_char: ch, out_is_char: 1'b1,
                                               out_last: 1'b0});
                end
            end
            fill = 0;
            in_tag = 1'b0;
            if (keep) want_beats.push_back('{out_char: 8'h00, out_is_char: 1'b0, out_last: 1'b1});
        end
    endtask

    task automatic commit_text(int row);
        t_in_beat b;
        for (int i = 0; i < text_buf.size(); i++) begin
            b.in_byte = text_buf[i];
            b.in_last = (i == text_buf.size() - 1);
            stim_q.push_back(b);
            stim_row.push_back(row);
        end
        text_buf.delete();
    endtask

    task automatic note_mismatch(string field, logic [7:0] e, logic [7:0] a);
        mismatches++;
        if (mismatches <= MaxReports)
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, e, a);
    endtask

    // input beat prediction and output beat checking
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                if (at_start && stim_row[acc_cnt] >= 0) begin
                    string w;
                    w = dir_want[stim_row[acc_cnt]];
                    if (w != "*") begin
                        for (int j = 0; j < w.len(); j++)
                            want_beats.push_back('{out_char: w[j], out_is_char: 1'b1,
                                                   out_last: 1'b0});
                        want_beats.push_back('{out_char: 8'h00, out_is_char: 1'b0,
                                               out_last: 1'b1});
                    end
                end
                predict_byte(i_in_data, stim_row[acc_cnt] < 0 ||
                             dir_want[stim_row[acc_cnt] < 0 ? 0 : stim_row[acc_cnt]] == "*");
                at_start = i_in_data.in_last;
                acc_cnt++;
            end
            if (o_out_valid && i_out_ready) begin
                if (want_beats.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MaxReports)
                        $display("%0t: unexpected beat, expected none, actual %h/%b/%b", $time,
                                 o_out_data.out_char, o_out_data.out_is_char,
                                 o_out_data.out_last);
                end else begin
                    t_out_beat e;
                    e = want_beats.pop_front();
                    if (o_out_data.out_char !== e.out_char)
                        note_mismatch("out_char", e.out_char, o_out_data.out_char);
                    if (o_out_data.out_is_char !== e.out_is_char)
                        note_mismatch("out_is_char", 8'(e.out_is_char),
                                      8'(o_out_data.out_is_char));
                    if (o_out_data.out_last !== e.out_last)
                        note_mismatch("out_last", 8'(e.out_last), 8'(o_out_data.out_last));
                end
            end
        end
    end

    // receiver: random-rate runs, plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (rx_cyc >= HoldStart && rx_cyc < HoldStart + HoldLen) begin
                i_out_ready <= 1'b0;
            end else begin
                if (run_left == 0) begin
                    run_left = $urandom_range(1, 40);
                    case ($urandom_range(0, 3))
                        0: ready_pct = 100;
                        1: ready_pct = 80;
                        2: ready_pct = 50;
                        default: ready_pct = 20;
                    endcase
                end
                run_left--;
                i_out_ready <= ($urandom_range(0, 99) < ready_pct);
            end
            rx_cyc++;
        end
    end

    always @(posedge i_clk) begin
        cyc_total++;
        if (cyc_total > CycleLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    int k;
    int burst_left;
    int gap;
    int rnd_count;
    int nfrag;
    int sel;
    string frag;
    logic [7:0] c;
    logic flip;
    logic noise;

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        mismatches = 0;
        acc_cnt = 0;
        cyc_total = 0;
        rx_cyc = 0;
        run_left = 0;
        ready_pct = 100;
        fill = 0;
        in_tag = 1'b0;
        foreach (win[i]) win[i] = 8'h00;

        for (int r = 0; r < DirRows; r++) begin
            frag = dir_text[r];
            for (int j = 0; j < frag.len(); j++) text_buf.push_back(frag[j]);
            commit_text(r);
        end

        rnd_count = 0;
        while (rnd_count < RandBytes) begin
            noise = ($urandom_range(0, 99) < 15);
            nfrag = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 25) : $urandom_range(1, 6);
            for (int f = 0; f < nfrag; f++) begin
                sel = noise ? NumFrags : $urandom_range(0, NumFrags);
                if (sel == NumFrags) begin
                    repeat ($urandom_range(1, 3)) text_buf.push_back(8'($urandom_range(1, 255)));
                end else begin
                    frag = frags[sel];
                    flip = ($urandom_range(0, 99) < 15);
                    for (int j = 0; j < frag.len(); j++) begin
                        c = frag[j];
                        if (flip && ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) &&
                            $urandom_range(0, 1))
                            c = c ^ 8'h20;
                        text_buf.push_back(c);
                    end
                end
            end
            rnd_count += text_buf.size();
            commit_text(-1);
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        k = 0;
        burst_left = 0;
        while (k < stim_q.size()) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = $urandom_range(0, 6);
                if (gap > 0) begin
                    i_in_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            i_in_valid <= 1'b1;
            i_in_data <= stim_q[k];
            @(posedge i_clk);
            while (!o_in_ready) @(posedge i_clk);
            k++;
            burst_left--;
        end
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        while (want_beats.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
